// ===== sv/trpb_pkg.sv =====
// ----------------------------------------------------------------------------
// trpb_pkg
// Types and constants for the tcp reset packet builder: header words of the
// reply and the per-copy record that travels down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package trpb_pkg;

   localparam logic [15:0] IP_VER_IHL_WORD   = 16'h4500;
   localparam logic [15:0] IP_TOTAL_LEN      = 16'h0028;
   localparam logic [15:0] IP_TTL_PROTO_WORD = 16'hFF06;
   localparam logic [15:0] RST_ACK_WORD      = 16'h5014;
   localparam logic [15:0] TCP_PSEUDO_TAIL   = 16'h001A;

   localparam int unsigned COUNT_W = 4;
   localparam int unsigned SUM_W   = 20;

   localparam logic [1:0] REG_RESET_COUNT = 2'd0;
   localparam logic [COUNT_W-1:0] RESET_COUNT_DEFAULT = 4'd2;

   typedef struct packed {
      logic [31:0] sip;
      logic [31:0] dip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] rack;
      logic [31:0] rseq;
      logic [15:0] win;
      logic        last;
   } copy_type;

endpackage

`default_nettype wire

// ===== sv/tcp_reset_packet_builder.sv =====
// ----------------------------------------------------------------------------
// tcp_reset_packet_builder
// Each observed tcp/ipv4 header item on req_ yields reset_count forged
// rst+ack replies on rsp_, addresses and ports swapped, with the ipv4 header
// checksum and the tcp checksum over the pseudo-header.
//
// Channels: req_ and rsp_ use valid/stall; an item moves at a rising edge
// with valid high and stall low. The apb-style port writes reset_count at
// byte address 0 (reset value 2); the user must write it only while the
// block is idle; the block itself does not enforce this. An item with count
// n occupies the copy generator until its n copies are issued, so one reply
// leaves per cycle while rsp_ is not stalled, and a new item is taken in the
// cycle its last copy is issued; an item with count 0 gives no reply.
// Pipeline: copy generator, register, partial sums, full sums, fold and
// output register. A stall on rsp_ freezes every stage but an idle copy
// generator, which may still take an item; nothing is lost or repeated and
// req_stall rises while the generator is held.
// Reset clears all valid bits and sets reset_count to 2.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_reset_packet_builder
   import trpb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [31:0] req_source_ip,
   input  wire logic [31:0] req_dest_ip,
   input  wire logic [15:0] req_source_port,
   input  wire logic [15:0] req_dest_port,
   input  wire logic [31:0] req_seq_number,
   input  wire logic [31:0] req_ack_number,
   input  wire logic [15:0] req_window_size,

   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_reply_src_ip,
   output      logic [31:0] rsp_reply_dst_ip,
   output      logic [15:0] rsp_ip_header_checksum,
   output      logic [15:0] rsp_reply_src_port,
   output      logic [15:0] rsp_reply_dst_port,
   output      logic [31:0] rsp_reply_seq,
   output      logic [31:0] rsp_reply_ack,
   output      logic [15:0] rsp_reply_window,
   output      logic [15:0] rsp_tcp_checksum,
   output      logic        rsp_last_copy,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);

   logic [COUNT_W-1:0] count_ff;
   logic               cfg_wr;

   logic               adv;
   logic               accept;

   logic               a_valid_ff, a_valid_in;
   copy_type           a_copy_ff, a_copy_in;
   logic [COUNT_W-1:0] a_count_ff, a_count_in;
   logic [COUNT_W-1:0] a_k_ff, a_k_in;
   logic               a_last;
   copy_type           a_out;

   logic               b_valid_ff;
   copy_type           b_copy_ff;

   logic               c_valid_ff;
   copy_type           c_copy_ff;
   logic [SUM_W-1:0]   c_addr_ff, c_addr_in;
   logic [SUM_W-1:0]   c_hdr_ff, c_hdr_in;

   logic               d_valid_ff;
   copy_type           d_copy_ff;
   logic [SUM_W-1:0]   d_ip_ff, d_ip_in;
   logic [SUM_W-1:0]   d_tcp_ff, d_tcp_in;

   logic               e_valid_ff;
   copy_type           e_copy_ff;
   logic [15:0]        e_ipck_ff, e_ipck_in;
   logic [15:0]        e_tcpck_ff, e_tcpck_in;

   function automatic logic [15:0] fold_invert(input logic [SUM_W-1:0] s);
      logic [16:0] f1;
      logic [16:0] f2;
      f1 = {1'b0, s[15:0]} + 17'(s[SUM_W-1:16]);
      f2 = {1'b0, f1[15:0]} + 17'(f1[16]);
      return ~f2[15:0];
   endfunction

   // configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr == REG_RESET_COUNT);
   assign prdata = (paddr == REG_RESET_COUNT) ? {28'd0, count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= RESET_COUNT_DEFAULT;
      end else if (cfg_wr) begin
         count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   // global advance
   assign adv = !(e_valid_ff && rsp_stall);

   // copy generator
   assign a_last    = (a_k_ff == (a_count_ff - 4'd1));
   assign req_stall = a_valid_ff && !(adv && a_last);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_copy_in  = a_copy_ff;
      a_count_in = a_count_ff;
      a_k_in     = a_k_ff;
      if (accept) begin
         a_valid_in      = (count_ff != '0);
         a_copy_in.sip   = req_source_ip;
         a_copy_in.dip   = req_dest_ip;
         a_copy_in.sport = req_source_port;
         a_copy_in.dport = req_dest_port;
         a_copy_in.rack  = req_seq_number + 32'd1;
         a_copy_in.rseq  = req_ack_number;
         a_copy_in.win   = req_window_size;
         a_copy_in.last  = 1'b0;
         a_count_in      = count_ff;
         a_k_in          = '0;
      end else if (a_valid_ff && adv) begin
         if (a_last) begin
            a_valid_in = 1'b0;
         end else begin
            a_k_in         = a_k_ff + 4'd1;
            a_copy_in.rseq = a_copy_ff.rseq + {16'd0, a_copy_ff.win};
         end
      end
   end

   always_comb begin
      a_out      = a_copy_ff;
      a_out.last = a_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (adv) begin
            b_valid_ff <= a_valid_ff;
            c_valid_ff <= b_valid_ff;
            d_valid_ff <= c_valid_ff;
            e_valid_ff <= d_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_copy_ff  <= a_copy_in;
      a_count_ff <= a_count_in;
      a_k_ff     <= a_k_in;
   end

   // partial sums
   assign c_addr_in = SUM_W'(b_copy_ff.dip[31:16]) + SUM_W'(b_copy_ff.dip[15:0])
                    + SUM_W'(b_copy_ff.sip[31:16]) + SUM_W'(b_copy_ff.sip[15:0]);
   assign c_hdr_in  = SUM_W'(b_copy_ff.dport) + SUM_W'(b_copy_ff.sport)
                    + SUM_W'(b_copy_ff.win) + SUM_W'(b_copy_ff.rack[31:16])
                    + SUM_W'(b_copy_ff.rack[15:0]) + SUM_W'(RST_ACK_WORD)
                    + SUM_W'(TCP_PSEUDO_TAIL);

   // full sums
   assign d_ip_in  = c_addr_ff + SUM_W'(IP_VER_IHL_WORD) + SUM_W'(IP_TOTAL_LEN)
                   + SUM_W'(IP_TTL_PROTO_WORD);
   assign d_tcp_in = c_addr_ff + c_hdr_ff + SUM_W'(c_copy_ff.rseq[31:16])
                   + SUM_W'(c_copy_ff.rseq[15:0]);

   // fold and invert
   assign e_ipck_in  = fold_invert(d_ip_ff);
   assign e_tcpck_in = fold_invert(d_tcp_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         b_copy_ff      <= a_out;
         c_copy_ff      <= b_copy_ff;
         c_addr_ff      <= c_addr_in;
         c_hdr_ff       <= c_hdr_in;
         d_copy_ff      <= c_copy_ff;
         d_ip_ff        <= d_ip_in;
         d_tcp_ff       <= d_tcp_in;
         e_copy_ff      <= d_copy_ff;
         e_ipck_ff      <= e_ipck_in;
         e_tcpck_ff     <= e_tcpck_in;
      end
   end

   assign rsp_valid              = e_valid_ff;
   assign rsp_reply_src_ip       = e_copy_ff.dip;
   assign rsp_reply_dst_ip       = e_copy_ff.sip;
   assign rsp_ip_header_checksum = e_ipck_ff;
   assign rsp_reply_src_port     = e_copy_ff.dport;
   assign rsp_reply_dst_port     = e_copy_ff.sport;
   assign rsp_reply_seq          = e_copy_ff.rseq;
   assign rsp_reply_ack          = e_copy_ff.rack;
   assign rsp_reply_window       = e_copy_ff.win;
   assign rsp_tcp_checksum       = e_tcpck_ff;
   assign rsp_last_copy          = e_copy_ff.last;

endmodule

`default_nettype wire
